### hw/rtl/rcm_pkg.sv
// Shared types and constants for the rainbow color map.
// Holds the pipeline stage layout, color constants and the ramp slope table.
// No dependencies.
`default_nettype none

package rcm_pkg;

  // Where a sample falls relative to the configured range.
  typedef enum logic [1:0] {
    CLS_RAMP,
    CLS_BELOW,
    CLS_ABOVE
  } cls_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_RANGE_HIGH = 2'd1;

  // Pipeline layout: front end, segment bits, multiply, ramp quotient bits, output.
  localparam int unsigned KBits      = 3;
  localparam int unsigned QBits      = 8;
  localparam int unsigned StKFirst   = 1;
  localparam int unsigned StMul      = StKFirst + KBits;
  localparam int unsigned StDivFirst = StMul + 1;
  localparam int unsigned StOut      = StDivFirst + QBits;
  localparam int unsigned NumStages  = StOut + 1;

  // Color constants.
  localparam logic [7:0] LEVEL_MAX    = 8'd255;
  localparam logic [7:0] LEVEL_ZERO   = 8'd0;
  localparam logic [7:0] LEVEL_VIOLET = 8'd150;
  localparam logic [7:0] LEVEL_ORANGE = 8'd152;

  // Segment codes.
  localparam logic [KBits-1:0] SEG_RED_ORANGE    = 3'd0;
  localparam logic [KBits-1:0] SEG_ORANGE_YELLOW = 3'd1;
  localparam logic [KBits-1:0] SEG_YELLOW_GREEN  = 3'd2;
  localparam logic [KBits-1:0] SEG_GREEN_CYAN    = 3'd3;
  localparam logic [KBits-1:0] SEG_CYAN_BLUE     = 3'd4;
  localparam logic [KBits-1:0] SEG_BLUE_VIOLET   = 3'd5;

  // Slope of the ramping channel in each segment.
  function automatic logic [7:0] slope_of(logic [KBits-1:0] seg);
    logic [7:0] slope;
    unique case (seg)
      SEG_RED_ORANGE:    slope = 8'd152;
      SEG_ORANGE_YELLOW: slope = 8'd102;
      SEG_YELLOW_GREEN:  slope = 8'd255;
      SEG_GREEN_CYAN:    slope = 8'd255;
      SEG_CYAN_BLUE:     slope = 8'd255;
      default:           slope = 8'd150;
    endcase
    return slope;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rainbow_color_map.sv
// Rainbow color map: scalar sample in, 8-bit RGB color out.
// Depends on rcm_pkg for the stage layout, color constants and slope table.
`default_nettype none

// The block maps each unsigned sample onto a rainbow running red, orange,
// yellow, green, cyan, blue and violet between range_low and range_high.
// Samples below range_low come out pure red, samples at or above range_high
// come out violet, which also covers an empty or inverted range. It is a
// fourteen-stage pipeline that takes one sample per clock, provided the
// output is not stalled. The stage count is set by the two dividers: three
// restoring stages find the segment (the bits of 6d/r) and eight more find
// the ramp quotient slope*e/r, one quotient bit per stage with one compare
// and subtract each; a multiply stage and the front and output stages
// complete it. A stall on the output freezes the whole pipeline, so no
// transfer is lost or repeated, and the input is stalled only while a
// finished color waits at the output. Configuration writes take effect at
// once and must be made while the pipeline is empty.
module rainbow_color_map #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rcm_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [VALUE_BITS-1:0]          cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [VALUE_BITS-1:0]          sample_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          red_level_o,
  output logic [7:0]                          green_level_o,
  output logic [7:0]                          blue_level_o
);
  import rcm_pkg::*;

  // Remainder width: holds 6d and the product slope*e.
  localparam int unsigned RW = VALUE_BITS + 8;

  logic [VALUE_BITS-1:0] range_low_q, range_high_q;
  logic [VALUE_BITS-1:0] range_w;

  logic              valid_q [NumStages];
  cls_e              cls_q   [StOut];
  cls_e              cls_d   [StOut];
  logic [RW-1:0]     rem_q   [StOut];
  logic [RW-1:0]     rem_d   [StOut];
  logic [KBits-1:0]  k_q     [StOut];
  logic [KBits-1:0]  k_d     [StOut];
  logic [QBits-1:0]  quo_q   [StOut];
  logic [QBits-1:0]  quo_d   [StOut];

  logic [7:0] red_q, green_q, blue_q;
  logic [7:0] red_d, green_d, blue_d;

  logic advance;

  // The whole pipeline moves unless a finished color is held at the output.
  assign advance    = !(valid_q[StOut] && out_stall_i);
  assign in_stall_o = !advance;
  assign range_w    = range_high_q - range_low_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= '0;
      range_high_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RANGE_LOW:  range_low_q  <= cfg_wdata_i;
        REG_RANGE_HIGH: range_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage logic. Past the front end, each stage uses the stage before; the divider stages also use r.
  always_comb begin
    logic [VALUE_BITS-1:0] d;
    logic [RW-1:0]         divisor;
    logic [RW-1:0]         e_ext;
    logic [RW-1:0]         slope_ext;

    // Front end: classify the sample and form 6d.
    d = sample_value_i - range_low_q;
    if (sample_value_i < range_low_q) begin
      cls_d[0] = CLS_BELOW;
    end else if (sample_value_i >= range_high_q) begin
      cls_d[0] = CLS_ABOVE;
    end else begin
      cls_d[0] = CLS_RAMP;
    end
    rem_d[0] = (RW'(d) << 2) + (RW'(d) << 1);
    k_d[0]   = '0;
    quo_d[0] = '0;

    divisor   = '0;
    e_ext     = '0;
    slope_ext = '0;

    for (int unsigned i = 1; i < StOut; i++) begin
      cls_d[i] = cls_q[i-1];
      rem_d[i] = rem_q[i-1];
      k_d[i]   = k_q[i-1];
      quo_d[i] = quo_q[i-1];
      if (i < StMul) begin
        // Segment bits, most significant first: compare against r shifted.
        divisor = RW'(range_w) << (StMul - 1 - i);
        if (rem_q[i-1] >= divisor) begin
          rem_d[i] = rem_q[i-1] - divisor;
          k_d[i][StMul-1-i] = 1'b1;
        end
      end else if (i == StMul) begin
        // The remainder is now e, below r; scale it by the segment slope.
        e_ext     = {8'b0, rem_q[i-1][VALUE_BITS-1:0]};
        slope_ext = {{VALUE_BITS{1'b0}}, slope_of(k_q[i-1])};
        rem_d[i]  = e_ext * slope_ext;
      end else begin
        // Ramp quotient bits, most significant first.
        divisor = RW'(range_w) << (StOut - 1 - i);
        if (rem_q[i-1] >= divisor) begin
          rem_d[i] = rem_q[i-1] - divisor;
          quo_d[i][StOut-1-i] = 1'b1;
        end
      end
    end
  end

  // Output stage: pick the channel levels for the class and, in the ramp, the segment.
  always_comb begin
    red_d   = LEVEL_ZERO;
    green_d = LEVEL_ZERO;
    blue_d  = LEVEL_ZERO;
    case (cls_q[StOut-1])
      CLS_BELOW: begin
        red_d = LEVEL_MAX;
      end
      CLS_ABOVE: begin
        red_d  = LEVEL_VIOLET;
        blue_d = LEVEL_MAX;
      end
      default: begin
        case (k_q[StOut-1])
          SEG_RED_ORANGE: begin
            red_d   = LEVEL_MAX;
            green_d = quo_q[StOut-1];
          end
          SEG_ORANGE_YELLOW: begin
            red_d   = LEVEL_MAX;
            green_d = LEVEL_ORANGE + quo_q[StOut-1];
          end
          SEG_YELLOW_GREEN: begin
            red_d   = LEVEL_MAX - quo_q[StOut-1];
            green_d = LEVEL_MAX;
          end
          SEG_GREEN_CYAN: begin
            green_d = LEVEL_MAX;
            blue_d  = quo_q[StOut-1];
          end
          SEG_CYAN_BLUE: begin
            green_d = LEVEL_MAX - quo_q[StOut-1];
            blue_d  = LEVEL_MAX;
          end
          default: begin
            red_d  = quo_q[StOut-1];
            blue_d = LEVEL_MAX;
          end
        endcase
      end
    endcase
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumStages; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (advance) begin
      valid_q[0] <= in_valid_i;
      for (int unsigned i = 1; i < NumStages; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int unsigned i = 0; i < StOut; i++) begin
        cls_q[i] <= cls_d[i];
        rem_q[i] <= rem_d[i];
        k_q[i]   <= k_d[i];
        quo_q[i] <= quo_d[i];
      end
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o   = valid_q[StOut];
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;

endmodule

`default_nettype wire

### test/tb_rainbow_color_map.sv
`timescale 1ns / 1ps
// Self-checking testbench for rainbow_color_map: directed and random streams of
// samples under several color ranges, every color checked against a predictor
// built in here. Depends on rcm_pkg and the rainbow_color_map RTL.

module tb_rainbow_color_map;
  import rcm_pkg::*;

  localparam int unsigned VALUE_BITS = 16;
  // The pipeline, output register included, is NumStages deep; the settle
  // wait adds margin on top of that.
  localparam int unsigned SETTLE_CYCLES = NumStages + 4;
  // Cycles without any transfer before the run is declared hung. The longest
  // quiet stretch in a correct run comes from pipeline fill plus the longest idle
  // on each side, or from a reconfiguration pause.
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned MAX_WAIT = 8;

  // The index field has room for two registers the block does not have.
  localparam logic [CfgIdxBits-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_UNMAPPED_B = 2'd3;

  // Slope of the ramping channel in each of the six segments.
  localparam int unsigned SLOPE_RED_ORANGE = 152;
  localparam int unsigned SLOPE_ORANGE_YELLOW = 102;
  localparam int unsigned SLOPE_FULL_SWING = 255;
  localparam int unsigned SLOPE_BLUE_VIOLET = 150;

  typedef logic [VALUE_BITS-1:0] value_t;
  localparam value_t VALUE_MAX = '1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Every input is known from time zero.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  value_t cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  value_t sample_value_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [7:0] red_level_o;
  logic [7:0] green_level_o;
  logic [7:0] blue_level_o;

  // Samples waiting to be sent, and colors waiting to come back, in order.
  value_t sample_q[$];
  color_t color_q[$];

  // The testbench's own copy of the two range registers.
  value_t range_lo = '0;
  value_t range_hi = VALUE_MAX;

  // Handshake bookkeeping; taken flags are set at rising edges, read at falling.
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_wait = 0;
  logic in_steady = 1'b0;
  logic out_steady = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;

  rainbow_color_map #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_value_i(sample_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Ramp of one channel across a segment: floor(slope * e / r), exact.
  function automatic logic [7:0] ramp_step(int unsigned slope, longint unsigned rem,
                                           longint unsigned span);
    return 8'((longint'(slope) * rem) / span);
  endfunction

  // Expected color of a sample under the current range. The below-range test
  // comes first, and both tests keep an empty or inverted range from division.
  function automatic color_t rainbow_color(value_t sample);
    longint unsigned span;
    longint unsigned dist6;
    longint unsigned seg;
    longint unsigned rem;
    color_t c;
    if (sample < range_lo) begin
      c = '{LEVEL_MAX, LEVEL_ZERO, LEVEL_ZERO};
    end else if (sample >= range_hi) begin
      c = '{LEVEL_VIOLET, LEVEL_ZERO, LEVEL_MAX};
    end else begin
      span = 64'(range_hi) - 64'(range_lo);
      dist6 = 64'(6) * (64'(sample) - 64'(range_lo));
      seg = dist6 / span;
      rem = dist6 - seg * span;
      case (seg[KBits-1:0])
        SEG_RED_ORANGE: begin
          c = '{LEVEL_MAX, ramp_step(SLOPE_RED_ORANGE, rem, span), LEVEL_ZERO};
        end
        SEG_ORANGE_YELLOW: begin
          c = '{LEVEL_MAX, LEVEL_ORANGE + ramp_step(SLOPE_ORANGE_YELLOW, rem, span),
                LEVEL_ZERO};
        end
        SEG_YELLOW_GREEN: begin
          c = '{LEVEL_MAX - ramp_step(SLOPE_FULL_SWING, rem, span), LEVEL_MAX, LEVEL_ZERO};
        end
        SEG_GREEN_CYAN: begin
          c = '{LEVEL_ZERO, LEVEL_MAX, ramp_step(SLOPE_FULL_SWING, rem, span)};
        end
        SEG_CYAN_BLUE: begin
          c = '{LEVEL_ZERO, LEVEL_MAX - ramp_step(SLOPE_FULL_SWING, rem, span), LEVEL_MAX};
        end
        default: begin
          c = '{ramp_step(SLOPE_BLUE_VIOLET, rem, span), LEVEL_ZERO, LEVEL_MAX};
        end
      endcase
    end
    return c;
  endfunction

  task automatic check_level(string channel, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s level expected %0d, got %0d", $time, channel, want, got);
      mismatch_count++;
    end
  endtask

  // One register write, one cycle wide. Writes to the unmapped indexes must not
  // touch either range register, so the local copy ignores them as well.
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, value_t data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_RANGE_LOW) begin
      range_lo = data;
    end else if (idx == REG_RANGE_HIGH) begin
      range_hi = data;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued sample has been sent and every color has come back,
  // then let the pipeline settle. Checked at the falling edge, when all
  // rising-edge bookkeeping is done.
  task automatic wait_until_drained;
    while (sample_q.size() != 0 || in_valid_i || color_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_range(value_t lo, value_t hi);
    wait_until_drained();
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
  endtask

  // Random range: mostly a proper range, sometimes the full scale, a range only
  // a few counts wide, or an empty or inverted one.
  task automatic pick_range;
    value_t lo;
    value_t hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = '0;
        hi = VALUE_MAX;
      end
      1: begin
        lo = value_t'($urandom_range(0, 65000));
        hi = value_t'(lo + $urandom_range(1, 12));
      end
      2: begin
        lo = value_t'($urandom);
        hi = value_t'($urandom_range(0, lo));
      end
      default: begin
        lo = value_t'($urandom_range(0, 60000));
        hi = value_t'($urandom_range(lo + 1, VALUE_MAX));
      end
    endcase
    set_range(lo, hi);
  endtask

  // Most samples land inside the range so that every segment gets exercised;
  // the rest are range edges or anything at all.
  function automatic value_t pick_sample();
    value_t s;
    case ($urandom_range(0, 9))
      0: s = value_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: s = value_t'(range_lo - 1);
          1: s = range_lo;
          2: s = value_t'(range_hi - 1);
          default: s = range_hi;
        endcase
      end
      default: begin
        if (range_hi > range_lo) begin
          s = value_t'($urandom_range(range_lo, range_hi - 1));
        end else begin
          s = value_t'($urandom);
        end
      end
    endcase
    return s;
  endfunction

  // Sender. A new sample goes out once the previous one has transferred and the
  // drawn idle time has run out. Valid stays high across back-to-back
  // transfers, and a stalled sample is held unchanged.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_valid_i <= 1'b1;
          sample_value_i <= sample_q.pop_front();
          if ($urandom_range(0, 31) == 0) begin
            in_steady = !in_steady;
          end
          in_gap = in_steady ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. After each color it draws how long to stall; in steady stretches
  // it never stalls at all.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 31) == 0) begin
          out_steady = !out_steady;
        end
        out_wait = out_steady ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait = out_wait - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor and scoreboard. Each sample transfer queues its predicted color;
  // each color transfer is compared with the oldest prediction. The watchdog
  // counts cycles in which neither side transfers.
  always @(posedge clk_i) begin
    color_t want;
    color_t got;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      out_taken <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) begin
        color_q.push_back(rainbow_color(sample_value_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{red_level_o, green_level_o, blue_level_o};
        if (color_q.size() == 0) begin
          $display("%0t: no color expected, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = color_q.pop_front();
          check_level("red", want.red, got.red);
          check_level("green", want.green, got.green);
          check_level("blue", want.blue, got.blue);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset range (full scale): both ends, the midpoint and a segment boundary.
    sample_q.push_back('0);
    sample_q.push_back(16'd1);
    sample_q.push_back(16'd10922);
    sample_q.push_back(16'd10923);
    sample_q.push_back(16'd32767);
    sample_q.push_back(value_t'(VALUE_MAX - 1));
    sample_q.push_back(VALUE_MAX);

    // A range of 6000 puts segment boundaries on whole thousands.
    set_range(16'd1000, 16'd7000);
    sample_q.push_back(16'd999);
    sample_q.push_back(16'd1000);
    sample_q.push_back(16'd1999);
    sample_q.push_back(16'd2000);
    sample_q.push_back(16'd5999);
    sample_q.push_back(16'd6999);
    sample_q.push_back(16'd7000);

    // Empty range; then writes to the unmapped indexes, which would turn the
    // samples below 500 into ramp colors if they landed on range_low.
    set_range(16'd500, 16'd500);
    wait_until_drained();
    write_reg(REG_UNMAPPED_A, '0);
    write_reg(REG_UNMAPPED_B, '0);
    sample_q.push_back(16'd499);
    sample_q.push_back(16'd500);
    sample_q.push_back(16'd250);

    // Narrowest proper range at each end of the scale.
    set_range('0, 16'd1);
    sample_q.push_back('0);
    sample_q.push_back(16'd1);
    set_range(value_t'(VALUE_MAX - 1), VALUE_MAX);
    sample_q.push_back(value_t'(VALUE_MAX - 2));
    sample_q.push_back(value_t'(VALUE_MAX - 1));
    sample_q.push_back(VALUE_MAX);

    // Inverted range: every sample is either below or at or above the end.
    set_range(16'd40000, 16'd100);
    sample_q.push_back('0);
    sample_q.push_back(16'd100);
    sample_q.push_back(16'd50000);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_range();
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        sample_q.push_back(pick_sample());
      end
    end

    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
